@@ src/refcounted_breakpoint_table_unit_defines.svh @@
// Assertion macros for the breakpoint table.
// RBT_ASSERT: a condition that holds at every clock edge out of reset.
// RBT_ASSERT_NEXT: an antecedent that forces a consequent in the following cycle.
`ifndef REFCOUNTED_BREAKPOINT_TABLE_UNIT_DEFINES_SVH
`define REFCOUNTED_BREAKPOINT_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define RBT_ASSERT(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`define RBT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RBT_ASSERT(lbl, clk, rstn, cond, msg)

`define RBT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ src/rbt_pkg.sv @@
package rbt_pkg;

  localparam int RH_W        = 5;
  localparam int ST_W        = 3;
  localparam int MODE_W      = 3;
  localparam int VM_W        = 16;
  localparam int TID_W       = 32;
  localparam int ADDR_W      = 32;
  localparam int HND_W       = 8;
  localparam int INST_W      = 3;
  localparam int EXT_W       = 32;
  localparam int CNT_W       = 16;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_SW = 3'd0,
    MODE_ADD_HW = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_FIND   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_GEN_ERR  = 3'd1;
  localparam logic [ST_W-1:0] ST_ROM      = 3'd2;
  localparam logic [ST_W-1:0] ST_COPY     = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_PAGES = 3'd4;

  localparam logic [INST_W-1:0] INST_OK       = 3'd0;
  localparam logic [INST_W-1:0] INST_ROM      = 3'd1;
  localparam logic [INST_W-1:0] INST_COPY     = 3'd2;
  localparam logic [INST_W-1:0] INST_NO_PAGES = 3'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [VM_W-1:0]   vm;
    logic [TID_W-1:0]  thread;
    logic [ADDR_W-1:0] addr;
    logic              b16;
    logic              hw;
    logic [EXT_W-1:0]  ext;
  } entry_t;

  typedef struct packed {
    logic [VM_W-1:0]   vm;
    logic [TID_W-1:0]  thread;
    logic [ADDR_W-1:0] addr;
  } key_t;

  typedef struct packed {
    logic sw;
    logic hw;
    logic find;
  } match_t;

endpackage

@@ src/refcounted_breakpoint_table_unit.sv @@
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+------------------------------
// command   | mode_i .. ext_handle_i                 | start high, busy low
// result    | result_handle_o .. last_o              | result_valid_o, one cycle
// config    | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// Entries are scanned one at a time through the shared comparator, each with a
// memory read step and a compare step. Add stops at a match or a rejected add,
// else scans to the end and then writes in a finish step; find stops at a hit or
// the last entry; clear visits all entries; delete and other commands use one.
// Reset clears the per-entry valid flops at once; no clearing pass is needed.
// Results cannot be stalled; busy stays high until the last beat is issued.
`include "refcounted_breakpoint_table_unit_defines.svh"

module refcounted_breakpoint_table_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command
  input  logic                        start,
  output logic                        busy,
  input  logic [rbt_pkg::MODE_W-1:0]  mode_i,
  input  logic [rbt_pkg::VM_W-1:0]    vm_id_i,
  input  logic [rbt_pkg::TID_W-1:0]   thread_id_i,
  input  logic [rbt_pkg::ADDR_W-1:0]  address_i,
  input  logic                        is_16bit_i,
  input  logic [rbt_pkg::HND_W-1:0]   handle_i,
  input  logic [rbt_pkg::INST_W-1:0]  install_status_i,
  input  logic [rbt_pkg::EXT_W-1:0]   ext_handle_i,
  // result
  output logic                        result_valid_o,
  output logic [rbt_pkg::RH_W-1:0]    result_handle_o,
  output logic [rbt_pkg::ST_W-1:0]    status_o,
  output logic                        success_o,
  output logic                        released_o,
  output logic [rbt_pkg::EXT_W-1:0]   released_ext_handle_o,
  output logic                        released_hw_o,
  output logic                        last_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rbt_pkg::*;

  localparam int IW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LAST_RES = (TABLE_ENTRIES < MAX_RESULTS) ? TABLE_ENTRIES : MAX_RESULTS;
  localparam logic CFG_HW_EN = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [RH_W-1:0]  rh;
    logic [ST_W-1:0]  st;
    logic             ok;
    logic             rel;
    logic [EXT_W-1:0] ext;
    logic             hw;
    logic             last;
  } res_t;

  function automatic res_t mk_res(logic [RH_W-1:0] rh, logic [ST_W-1:0] st, logic ok,
                                  logic rel, logic [EXT_W-1:0] ext, logic hw,
                                  logic last);
    res_t r;
    r.rh   = rh;
    r.st   = st;
    r.ok   = ok;
    r.rel  = rel;
    r.ext  = ext;
    r.hw   = hw;
    r.last = last;
    return r;
  endfunction

  function automatic logic [RH_W-1:0] rh_of(logic [IW-1:0] i);
    return RH_W'(32'(i) + 32'd1);
  endfunction

  function automatic logic [ST_W-1:0] inst_status(logic [INST_W-1:0] s);
    logic [ST_W-1:0] st;
    priority case (s)
      INST_ROM:      st = ST_ROM;
      INST_COPY:     st = ST_COPY;
      INST_NO_PAGES: st = ST_NO_PAGES;
      default:       st = ST_GEN_ERR;
    endcase
    return st;
  endfunction

  state_e                 state_q;
  mode_e                  mode_q;
  key_t                   key_q;
  logic                   b16_q;
  logic [INST_W-1:0]      inst_q;
  logic [EXT_W-1:0]       ext_q;
  logic                   bad_q;
  logic [IW-1:0]          idx_q;
  logic [IW-1:0]          free_q;
  logic                   free_found_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                   rdv_q;
  entry_t                 rd_q;
  logic                   hw_en_q;
  res_t                   res_q;
  logic                   res_valid_q;
  logic                   wr_en_q;
  logic [IW-1:0]          wr_addr_q;
  entry_t                 wr_data_q;

  entry_t                 mem [TABLE_ENTRIES];

  match_t                 hit;
  entry_t                 bump_ent;
  entry_t                 dec_ent;
  entry_t                 new_ent;
  logic                   at_end;
  logic                   cfg_wr;
  logic                   is_sw;

  rbt_match u_match (
    .ent_i      (rd_q),
    .ent_valid_i(rdv_q),
    .key_i      (key_q),
    .hit_o      (hit)
  );

  assign at_end = idx_q == IW'(TABLE_ENTRIES - 1);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign is_sw  = mode_q == MODE_ADD_SW;

  always_comb begin
    bump_ent     = rd_q;
    bump_ent.cnt = (rd_q.cnt == CNT_MAX) ? rd_q.cnt : rd_q.cnt + CNT_ONE;
    dec_ent      = rd_q;
    dec_ent.cnt  = rd_q.cnt - CNT_ONE;
    // a hardware entry keeps space, thread and mode bit at zero
    new_ent.cnt    = CNT_ONE;
    new_ent.vm     = is_sw ? key_q.vm : '0;
    new_ent.thread = is_sw ? key_q.thread : '0;
    new_ent.addr   = key_q.addr;
    new_ent.b16    = is_sw ? b16_q : 1'b0;
    new_ent.hw     = !is_sw;
    new_ent.ext    = ext_q;
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_q) begin
      mem[wr_addr_q] <= wr_data_q;
    end
    if (state_q == S_READ) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      hw_en_q      <= 1'b0;
      res_q        <= '0;
      res_valid_q  <= 1'b0;
      wr_en_q      <= 1'b0;
      free_found_q <= 1'b0;
      rdv_q        <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      res_q       <= '0;
      wr_en_q     <= 1'b0;
      if (cfg_wr && paddr[2] == CFG_HW_EN) begin
        hw_en_q <= pwdata[0];
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            mode_q       <= mode_e'(mode_i);
            key_q.vm     <= vm_id_i;
            key_q.thread <= thread_id_i;
            key_q.addr   <= address_i;
            b16_q        <= is_16bit_i;
            inst_q       <= install_status_i;
            ext_q        <= ext_handle_i;
            free_found_q <= 1'b0;
            if (mode_e'(mode_i) == MODE_DELETE) begin
              bad_q <= 32'(handle_i) >= TABLE_ENTRIES;
              idx_q <= (32'(handle_i) >= TABLE_ENTRIES) ? '0 : IW'(handle_i);
            end else begin
              bad_q <= (mode_e'(mode_i) == MODE_ADD_HW) && !hw_en_q;
              idx_q <= '0;
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          rdv_q   <= valid_q[idx_q];
          state_q <= S_CMP;
        end
        S_CMP: begin
          unique case (mode_q)
            MODE_ADD_SW, MODE_ADD_HW: begin
              if (bad_q) begin
                res_q       <= mk_res('0, ST_GEN_ERR, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                res_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end else if (is_sw ? hit.sw : hit.hw) begin
                wr_en_q     <= 1'b1;
                wr_addr_q   <= idx_q;
                wr_data_q   <= bump_ent;
                res_q       <= mk_res(rh_of(idx_q), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
                res_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end else begin
                if (!rdv_q && !free_found_q) begin
                  free_found_q <= 1'b1;
                  free_q       <= idx_q;
                end
                if (at_end) begin
                  state_q <= S_FINISH;
                end else begin
                  idx_q   <= idx_q + 1'b1;
                  state_q <= S_READ;
                end
              end
            end
            MODE_FIND: begin
              if (hit.find) begin
                res_q       <= mk_res(rh_of(idx_q), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
                res_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end else if (at_end) begin
                res_q       <= mk_res('0, ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                res_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end else begin
                idx_q   <= idx_q + 1'b1;
                state_q <= S_READ;
              end
            end
            MODE_DELETE: begin
              res_valid_q <= 1'b1;
              state_q     <= S_IDLE;
              if (bad_q || !rdv_q) begin
                res_q <= mk_res('0, ST_GEN_ERR, 1'b0, 1'b0, '0, 1'b0, 1'b1);
              end else if (rd_q.cnt == CNT_ONE) begin
                valid_q[idx_q] <= 1'b0;
                res_q <= mk_res(rh_of(idx_q), ST_OK, 1'b1, 1'b1, rd_q.ext, rd_q.hw, 1'b1);
              end else begin
                wr_en_q   <= 1'b1;
                wr_addr_q <= idx_q;
                wr_data_q <= dec_ent;
                res_q <= mk_res(rh_of(idx_q), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
              end
            end
            MODE_CLEAR: begin
              // only the first MAX_RESULTS entries report a beat
              if (32'(idx_q) < LAST_RES) begin
                res_q <= mk_res(rh_of(idx_q), ST_OK, 1'b1, rdv_q,
                                rdv_q ? rd_q.ext : '0, rdv_q && rd_q.hw,
                                idx_q == IW'(LAST_RES - 1));
                res_valid_q <= 1'b1;
              end
              valid_q[idx_q] <= 1'b0;
              if (at_end) begin
                state_q <= S_IDLE;
              end else begin
                idx_q   <= idx_q + 1'b1;
                state_q <= S_READ;
              end
            end
            default: begin
              res_q       <= mk_res('0, ST_GEN_ERR, 1'b0, 1'b0, '0, 1'b0, 1'b1);
              res_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          endcase
        end
        S_FINISH: begin
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
          priority if (!free_found_q) begin
            res_q <= mk_res('0, ST_GEN_ERR, 1'b0, 1'b0, '0, 1'b0, 1'b1);
          end else if (inst_q != INST_OK) begin
            res_q <= mk_res('0, is_sw ? inst_status(inst_q) : ST_GEN_ERR, 1'b0, 1'b0, '0,
                            1'b0, 1'b1);
          end else begin
            wr_en_q         <= 1'b1;
            wr_addr_q       <= free_q;
            wr_data_q       <= new_ent;
            valid_q[free_q] <= 1'b1;
            res_q <= mk_res(rh_of(free_q), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                  = state_q != S_IDLE;
  assign result_valid_o        = res_valid_q;
  assign result_handle_o       = res_q.rh;
  assign status_o              = res_q.st;
  assign success_o             = res_q.ok;
  assign released_o            = res_q.rel;
  assign released_ext_handle_o = res_q.ext;
  assign released_hw_o         = res_q.hw;
  assign last_o                = res_q.last;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_HW_EN) ? {31'd0, hw_en_q} : 32'd0;

  `RBT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy,
                   "command beat not taken")
  `RBT_ASSERT(a_rel_beat, clk_i, rst_ni,
              !released_o || (result_valid_o && success_o), "stray release")
  `RBT_ASSERT_NEXT(a_last_gap, clk_i, rst_ni, result_valid_o && last_o, !result_valid_o,
                   "beat after last")
  `RBT_ASSERT(a_fail_handle, clk_i, rst_ni,
              !result_valid_o || success_o || result_handle_o == '0, "handle on failure")

endmodule

@@ src/rbt_match.sv @@
// Shared comparator: one stored entry against the key of the current command.
module rbt_match (
  input  rbt_pkg::entry_t ent_i,
  input  logic            ent_valid_i,
  input  rbt_pkg::key_t   key_i,
  output rbt_pkg::match_t hit_o
);
  import rbt_pkg::*;

  logic vm_eq, thr_eq, addr_eq;

  assign vm_eq   = ent_i.vm == key_i.vm;
  assign thr_eq  = ent_i.thread == key_i.thread;
  assign addr_eq = ent_i.addr == key_i.addr;

  assign hit_o.sw   = ent_valid_i && vm_eq && thr_eq && addr_eq;
  assign hit_o.hw   = ent_valid_i && ent_i.hw && addr_eq;
  assign hit_o.find = ent_valid_i && vm_eq && addr_eq;

endmodule

@@ tb/rbt_checker.sv @@
module rbt_checker #(
  parameter int         TABLE_ENTRIES = 16,
  parameter logic [2:0] HW_EN_ADDR    = 3'd0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic [rbt_pkg::MODE_W-1:0]  mode_i,
  input  logic [rbt_pkg::VM_W-1:0]    vm_id_i,
  input  logic [rbt_pkg::TID_W-1:0]   thread_id_i,
  input  logic [rbt_pkg::ADDR_W-1:0]  address_i,
  input  logic                        is_16bit_i,
  input  logic [rbt_pkg::HND_W-1:0]   handle_i,
  input  logic [rbt_pkg::INST_W-1:0]  install_status_i,
  input  logic [rbt_pkg::EXT_W-1:0]   ext_handle_i,
  input  logic                        result_valid_o,
  input  logic [rbt_pkg::RH_W-1:0]    result_handle_o,
  input  logic [rbt_pkg::ST_W-1:0]    status_o,
  input  logic                        success_o,
  input  logic                        released_o,
  input  logic [rbt_pkg::EXT_W-1:0]   released_ext_handle_o,
  input  logic                        released_hw_o,
  input  logic                        last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import rbt_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int LAST_SLOT   = (TABLE_ENTRIES < MAX_RESULTS) ? TABLE_ENTRIES : MAX_RESULTS;

  typedef struct packed {
    logic [RH_W-1:0]  rh;
    logic [ST_W-1:0]  st;
    logic             ok;
    logic             rel;
    logic [EXT_W-1:0] rel_ext;
    logic             rel_hw;
    logic             lst;
  } bp_reply_t;

  entry_t    shadow_table [TABLE_ENTRIES];
  logic      hw_bp_en;
  bp_reply_t awaited_replies [$];
  bp_reply_t got;
  bp_reply_t want;
  int        mismatches = 0;

  function automatic void push_reply(logic [RH_W-1:0] rh, logic [ST_W-1:0] st, logic ok,
                                     logic rel, logic [EXT_W-1:0] rel_ext, logic rel_hw,
                                     logic lst);
    bp_reply_t r;
    r.rh      = rh;
    r.st      = st;
    r.ok      = ok;
    r.rel     = rel;
    r.rel_ext = rel_ext;
    r.rel_hw  = rel_hw;
    r.lst     = lst;
    awaited_replies.push_back(r);
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (shadow_table[i].cnt == '0) return i;
    return -1;
  endfunction

  function automatic void bump_count(int i);
    if (shadow_table[i].cnt != CNT_MAX) shadow_table[i].cnt++;
  endfunction

  // Updates the shadow table for one accepted command and queues its beats.
  function automatic void run_table_command(logic [MODE_W-1:0] mode, logic [VM_W-1:0] vm,
                                            logic [TID_W-1:0] thr, logic [ADDR_W-1:0] addr,
                                            logic b16, logic [HND_W-1:0] hnd,
                                            logic [INST_W-1:0] inst, logic [EXT_W-1:0] ext);
    int          hit;
    int          slot;
    logic        used;
    entry_t      e;
    logic [ST_W-1:0] st;
    hit = -1;
    case (mode)
      MODE_ADD_SW: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (hit < 0 && shadow_table[i].cnt != '0 && shadow_table[i].thread == thr &&
              shadow_table[i].addr == addr && shadow_table[i].vm == vm) hit = i;
        slot = first_free_slot();
        if (hit >= 0) begin
          bump_count(hit);
          push_reply(RH_W'(hit + 1), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
        end else if (slot < 0) begin
          push_reply('0, ST_GEN_ERR, 1'b0, 1'b0, '0, 1'b0, 1'b1);
        end else if (inst != INST_OK) begin
          case (inst)
            INST_ROM:      st = ST_ROM;
            INST_COPY:     st = ST_COPY;
            INST_NO_PAGES: st = ST_NO_PAGES;
            default:       st = ST_GEN_ERR;
          endcase
          push_reply('0, st, 1'b0, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          e        = '0;
          e.cnt    = CNT_ONE;
          e.vm     = vm;
          e.thread = thr;
          e.addr   = addr;
          e.b16    = b16;
          e.ext    = ext;
          shadow_table[slot] = e;
          push_reply(RH_W'(slot + 1), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
        end
      end
      MODE_ADD_HW: begin
        if (!hw_bp_en) begin
          push_reply('0, ST_GEN_ERR, 1'b0, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (hit < 0 && shadow_table[i].cnt != '0 && shadow_table[i].hw &&
                shadow_table[i].addr == addr) hit = i;
          slot = first_free_slot();
          if (hit >= 0) begin
            bump_count(hit);
            push_reply(RH_W'(hit + 1), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
          end else if (slot < 0 || inst != INST_OK) begin
            push_reply('0, ST_GEN_ERR, 1'b0, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            e      = '0;
            e.cnt  = CNT_ONE;
            e.hw   = 1'b1;
            e.addr = addr;
            e.ext  = ext;
            shadow_table[slot] = e;
            push_reply(RH_W'(slot + 1), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
          end
        end
      end
      MODE_DELETE: begin
        if (int'(hnd) >= TABLE_ENTRIES || shadow_table[hnd].cnt == '0) begin
          push_reply('0, ST_GEN_ERR, 1'b0, 1'b0, '0, 1'b0, 1'b1);
        end else begin
          shadow_table[hnd].cnt--;
          if (shadow_table[hnd].cnt == '0) begin
            push_reply(RH_W'(hnd + 1), ST_OK, 1'b1, 1'b1, shadow_table[hnd].ext,
                       shadow_table[hnd].hw, 1'b1);
            shadow_table[hnd] = '0;
          end else begin
            push_reply(RH_W'(hnd + 1), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
          end
        end
      end
      MODE_FIND: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (hit < 0 && shadow_table[i].cnt != '0 && shadow_table[i].vm == vm &&
              shadow_table[i].addr == addr) hit = i;
        if (hit >= 0) push_reply(RH_W'(hit + 1), ST_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
        else push_reply('0, ST_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
      end
      MODE_CLEAR: begin
        // one beat per entry up to the result limit, the rest cleared silently
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          used = (shadow_table[i].cnt != '0);
          if (i < LAST_SLOT)
            push_reply(RH_W'(i + 1), ST_OK, 1'b1, used, used ? shadow_table[i].ext : '0,
                       used ? shadow_table[i].hw : 1'b0, (i + 1 == LAST_SLOT));
          shadow_table[i] = '0;
        end
      end
      default: push_reply('0, ST_GEN_ERR, 1'b0, 1'b0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hw_bp_en = 1'b0;
      foreach (shadow_table[i]) shadow_table[i] = '0;
      awaited_replies.delete();
    end else begin
      // beats of the previous command come first, then any new command
      if (result_valid_o) begin
        got.rh      = result_handle_o;
        got.st      = status_o;
        got.ok      = success_o;
        got.rel     = released_o;
        got.rel_ext = released_ext_handle_o;
        got.rel_hw  = released_hw_o;
        got.lst     = last_o;
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected beat rh=%0d st=%0d ok=%b rel=%b ext=%h hw=%b last=%b",
                     $realtime, got.rh, got.st, got.ok, got.rel, got.rel_ext, got.rel_hw,
                     got.lst);
        end else begin
          want = awaited_replies.pop_front();
          if (got.rh !== want.rh || got.st !== want.st || got.ok !== want.ok ||
              got.rel !== want.rel || got.rel_ext !== want.rel_ext ||
              got.rel_hw !== want.rel_hw || got.lst !== want.lst) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: beat mismatch: expected rh=%0d st=%0d ok=%b rel=%b ext=%h hw=%b last=%b",
                       $realtime, want.rh, want.st, want.ok, want.rel, want.rel_ext,
                       want.rel_hw, want.lst);
              $display("%0t:                got rh=%0d st=%0d ok=%b rel=%b ext=%h hw=%b last=%b",
                       $realtime, got.rh, got.st, got.ok, got.rel, got.rel_ext,
                       got.rel_hw, got.lst);
            end
          end
        end
      end
      if (start && !busy)
        run_table_command(mode_i, vm_id_i, thread_id_i, address_i, is_16bit_i, handle_i,
                          install_status_i, ext_handle_i);
      if (psel && penable && pwrite && pready && paddr == HW_EN_ADDR)
        hw_bp_en = pwdata[0];
    end
    replies_due <= awaited_replies.size();
    fail_count  <= mismatches;
  end

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbt_pkg::*;

  localparam int                TABLE_ENTRIES    = 16;
  localparam logic [2:0]        HW_EN_ADDR       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI   = 3'd7;
  localparam int                SETTLE_CYCLES    = 2 * TABLE_ENTRIES + 8;
  localparam int                MAX_GAP          = 40;
  localparam int                STALL_LIMIT      = 2000;
  localparam int                RANDOM_PER_PHASE = 100;
  localparam int                REPEAT_ADDS      = 8;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [VM_W-1:0]   vm;
    logic [TID_W-1:0]  thread;
    logic [ADDR_W-1:0] addr;
    logic              b16;
    logic [HND_W-1:0]  hnd;
    logic [INST_W-1:0] inst;
    logic [EXT_W-1:0]  ext;
  } bp_cmd_t;

  logic clk = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [MODE_W-1:0] mode_i;
  logic [VM_W-1:0]   vm_id_i;
  logic [TID_W-1:0]  thread_id_i;
  logic [ADDR_W-1:0] address_i;
  logic              is_16bit_i;
  logic [HND_W-1:0]  handle_i;
  logic [INST_W-1:0] install_status_i;
  logic [EXT_W-1:0]  ext_handle_i;
  logic              result_valid_o;
  logic [RH_W-1:0]   result_handle_o;
  logic [ST_W-1:0]   status_o;
  logic              success_o;
  logic              released_o;
  logic [EXT_W-1:0]  released_ext_handle_o;
  logic              released_hw_o;
  logic              last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                replies_due;

  logic [VM_W-1:0]   vm_pool   [4];
  logic [TID_W-1:0]  thr_pool  [4];
  logic [ADDR_W-1:0] addr_pool [8];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  refcounted_breakpoint_table_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
    .clk_i(clk), .rst_ni(rst_ni),
    .start(start), .busy(busy),
    .mode_i(mode_i), .vm_id_i(vm_id_i), .thread_id_i(thread_id_i), .address_i(address_i),
    .is_16bit_i(is_16bit_i), .handle_i(handle_i), .install_status_i(install_status_i),
    .ext_handle_i(ext_handle_i),
    .result_valid_o(result_valid_o), .result_handle_o(result_handle_o), .status_o(status_o),
    .success_o(success_o), .released_o(released_o),
    .released_ext_handle_o(released_ext_handle_o), .released_hw_o(released_hw_o),
    .last_o(last_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  rbt_checker #(.TABLE_ENTRIES(TABLE_ENTRIES), .HW_EN_ADDR(HW_EN_ADDR)) u_checker (
    .clk_i(clk), .rst_ni(rst_ni),
    .start(start), .busy(busy),
    .mode_i(mode_i), .vm_id_i(vm_id_i), .thread_id_i(thread_id_i), .address_i(address_i),
    .is_16bit_i(is_16bit_i), .handle_i(handle_i), .install_status_i(install_status_i),
    .ext_handle_i(ext_handle_i),
    .result_valid_o(result_valid_o), .result_handle_o(result_handle_o), .status_o(status_o),
    .success_o(success_o), .released_o(released_o),
    .released_ext_handle_o(released_ext_handle_o), .released_hw_o(released_hw_o),
    .last_o(last_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .fail_count(fail_count), .replies_due(replies_due)
  );

  function automatic bp_cmd_t make_cmd(logic [MODE_W-1:0] mode, logic [VM_W-1:0] vm,
                                       logic [TID_W-1:0] thr, logic [ADDR_W-1:0] addr,
                                       logic b16, logic [HND_W-1:0] hnd,
                                       logic [INST_W-1:0] inst, logic [EXT_W-1:0] ext);
    bp_cmd_t c;
    c.mode   = mode;
    c.vm     = vm;
    c.thread = thr;
    c.addr   = addr;
    c.b16    = b16;
    c.hnd    = hnd;
    c.inst   = inst;
    c.ext    = ext;
    return c;
  endfunction

  // Keys come mostly from small pools so that adds match and the table fills.
  function automatic bp_cmd_t random_command();
    bp_cmd_t     c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 42)      c.mode = MODE_ADD_SW;
    else if (pick < 54) c.mode = MODE_ADD_HW;
    else if (pick < 78) c.mode = MODE_DELETE;
    else if (pick < 94) c.mode = MODE_FIND;
    else if (pick < 97) c.mode = MODE_CLEAR;
    else                c.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    c.vm     = ($urandom_range(4) == 0) ? VM_W'($urandom) : vm_pool[$urandom_range(3)];
    c.thread = ($urandom_range(4) == 0) ? TID_W'($urandom) : thr_pool[$urandom_range(3)];
    c.addr   = ($urandom_range(4) == 0) ? ADDR_W'($urandom) : addr_pool[$urandom_range(7)];
    c.b16    = 1'($urandom);
    c.hnd    = ($urandom_range(9) < 8) ? HND_W'($urandom_range(TABLE_ENTRIES - 1))
                                       : HND_W'($urandom);
    c.inst   = ($urandom_range(4) == 0) ? INST_W'($urandom_range(1, (1 << INST_W) - 1))
                                        : INST_OK;
    c.ext    = EXT_W'($urandom);
    return c;
  endfunction

  task automatic send_command(input bp_cmd_t c, input int idle_pct);
    int gap;
    gap = 0;
    if (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      do begin
        @(posedge clk);
        gap++;
      end while (int'($urandom_range(99)) < idle_pct && gap < MAX_GAP);
    end
    mode_i           <= c.mode;
    vm_id_i          <= c.vm;
    thread_id_i      <= c.thread;
    address_i        <= c.addr;
    is_16bit_i       <= c.b16;
    handle_i         <= c.hnd;
    install_status_i <= c.inst;
    ext_handle_i     <= c.ext;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Waits for every outstanding beat, then lets the scan of an item run out.
  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (replies_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hw_enable(input logic en);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HW_EN_ADDR;
    pwdata  <= {31'b0, en};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_random_phase(input logic hw_en, input int idle_pct);
    drain_replies();
    write_hw_enable(hw_en);
    repeat (RANDOM_PER_PHASE) send_command(random_command(), idle_pct);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || result_valid_o || !rst_ni) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    bp_cmd_t rep_key;
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    mode_i           <= '0;
    vm_id_i          <= '0;
    thread_id_i      <= '0;
    address_i        <= '0;
    is_16bit_i       <= 1'b0;
    handle_i         <= '0;
    install_status_i <= '0;
    ext_handle_i     <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // hardware breakpoints off
    write_hw_enable(1'b0);
    send_command(make_cmd(MODE_FIND, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_ADD_HW, '0, '0, 32'h0000_1000, 1'b0, '0, INST_OK, '1), 0);
    send_command(make_cmd(MODE_DELETE, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_DELETE, '0, '0, '0, 1'b0, '1, INST_OK, '0), 0);
    send_command(make_cmd(MODE_DELETE, '0, '0, '0, 1'b0, HND_W'(TABLE_ENTRIES), INST_OK, '0),
                 0);
    send_command(make_cmd(MODE_UNUSED_LO, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_UNUSED_HI, '1, '1, '1, 1'b1, '1, '1, '1), 0);
    send_command(make_cmd(MODE_ADD_SW, '1, '1, '1, 1'b1, '0, INST_OK, '1), 0);
    send_command(make_cmd(MODE_ADD_SW, '1, '1, '1, 1'b1, '0, INST_OK, 32'h1234_5678), 0);
    // every installer failure code on a fresh key
    for (int s = 1; s < (1 << INST_W); s++)
      send_command(make_cmd(MODE_ADD_SW, '0, '0, 32'h0000_0010, 1'b0, '0, INST_W'(s), '1), 0);
    send_command(make_cmd(MODE_FIND, '1, '0, '1, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_FIND, '0, '0, '1, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_DELETE, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_DELETE, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_ADD_SW, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_CLEAR, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);

    // hardware breakpoints on, software add sharing a hardware entry
    drain_replies();
    write_hw_enable(1'b1);
    send_command(make_cmd(MODE_ADD_HW, '1, '1, 32'h0000_1000, 1'b1, '0, INST_OK,
                          32'hA5A5_5A5A), 0);
    send_command(make_cmd(MODE_ADD_HW, '0, '0, 32'h0000_1000, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_ADD_SW, '0, '0, 32'h0000_1000, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_ADD_HW, '0, '0, 32'h0000_2000, 1'b0, '0, INST_COPY, '0), 0);
    repeat (3)
      send_command(make_cmd(MODE_DELETE, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);

    // fill the table, then overflow it both ways
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_command(make_cmd(MODE_ADD_SW, 16'h0042, '0, ADDR_W'(32'h8000_0000 + i * 4),
                            1'(i), '0, INST_OK, EXT_W'($urandom)), 0);
    send_command(make_cmd(MODE_ADD_SW, 16'h0042, '0, 32'h0000_0100, 1'b0, '0, INST_OK, '0),
                 0);
    send_command(make_cmd(MODE_ADD_HW, '0, '0, 32'h0000_0100, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_CLEAR, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);

    // stack several references on one key, then drop one
    rep_key = make_cmd(MODE_ADD_SW, 16'h5A5A, 32'h0000_0007, 32'h0040_0000, 1'b0, '0,
                       INST_OK, 32'hCAFE_0001);
    repeat (REPEAT_ADDS) send_command(rep_key, 0);
    send_command(make_cmd(MODE_FIND, 16'h5A5A, '0, 32'h0040_0000, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_DELETE, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);
    send_command(make_cmd(MODE_CLEAR, '0, '0, '0, 1'b0, '0, INST_OK, '0), 0);

    vm_pool   = '{16'h0000, 16'hFFFF, VM_W'($urandom), VM_W'($urandom)};
    thr_pool  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
    addr_pool = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
    run_random_phase(1'b1, 13);
    run_random_phase(1'b0, 78);
    run_random_phase(1'b1, 0);

    drain_replies();
    if (fail_count == 0 && replies_due == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
